// ===== rtl/sbie_pkg.sv =====
// Package for the stored-block image extractor.
// Holds the signature constants, status codes and the match result type.
// No dependencies.
package sbie_pkg;

  localparam int unsigned WinLen = 20;
  localparam int unsigned SigLen = 8;
  localparam int unsigned TailOfs = 12;
  localparam logic [3:0] SkipAfterMiss = 4'd12;
  localparam logic [2:0] HdrLast = 3'd4;
  localparam logic [15:0] FirstBlockLen = 16'h8000;
  localparam logic [4:0] WinFull = 5'd20;

  typedef logic [7:0] byte_t;

  localparam byte_t SigMagic [SigLen] = '{
    8'h07, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h0A, 8'h04
  };
  localparam byte_t SigTail [SigLen] = '{
    8'h00, 8'h78, 8'h01, 8'h00, 8'h00, 8'h80, 8'hFF, 8'h7F
  };

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StTrunc    = 2'd2
  } status_e;

  typedef struct packed {
    logic magic;
    logic tail;
  } match_t;

endpackage

// ===== rtl/sbie_in_if.sv =====
// Input channel of the stored-block image extractor: one file byte per transaction.
// Depends on nothing.
interface sbie_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;

  modport source (output valid, output data_byte, output end_of_file, input ready);
  modport sink (input valid, input data_byte, input end_of_file, output ready);
endinterface

// ===== rtl/sbie_out_if.sv =====
// Output channel of the stored-block image extractor: payload bytes and file status.
// Depends on nothing.
interface sbie_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       payload_valid;
  logic       file_done;
  logic [1:0] status;

  modport source (output valid, output out_byte, output payload_valid,
                  output file_done, output status, input ready);
  modport sink (input valid, input out_byte, input payload_valid,
                input file_done, input status, output ready);
endinterface

// ===== rtl/sbie_match.sv =====
// Signature matcher: checks the shifted search window for the magic and the tail.
// Depends on sbie_pkg.
module sbie_match
  import sbie_pkg::*;
(
  input  byte_t  win_i [WinLen],
  input  byte_t  byte_i,
  output match_t match_o
);

  byte_t nxt [WinLen];

  always_comb begin
    for (int i = 0; i < WinLen - 1; i++) begin
      nxt[i] = win_i[i+1];
    end
    nxt[WinLen-1] = byte_i;
  end

  always_comb begin
    match_o.magic = 1'b1;
    match_o.tail  = 1'b1;
    for (int i = 0; i < SigLen; i++) begin
      if (nxt[i] != SigMagic[i]) begin
        match_o.magic = 1'b0;
      end
      if (nxt[TailOfs+i] != SigTail[i]) begin
        match_o.tail = 1'b0;
      end
    end
  end

endmodule

// ===== rtl/stored_block_image_extractor.sv =====
// Stored-block image extractor, top level.
// Depends on sbie_pkg, sbie_in_if, sbie_out_if and sbie_match.
//
// The in_i channel takes one byte of a container file per transaction, with
// end_of_file marking the last byte. The block looks for the 8-byte magic
// followed 12 bytes later by the zlib/stored-block tail, then follows the
// chain of 5-byte stored-block headers and passes the payload bytes on.
// The out_o channel carries one transaction per payload byte and one for the
// last file byte, which has file_done set and the status: ok, start not
// found, or block truncated. A truncated block has already been sent, and the
// receiver is expected to discard it.
// Each byte is handled in the cycle it is accepted and its result is registered
// in the output register. A byte is accepted every cycle while the output
// register is empty or being taken. When the receiver stalls, the pending
// result is held and in_i.ready drops until it is taken. Reset clears the
// search and parser state; after the last file byte the same state returns
// to its reset value for the next file.
module stored_block_image_extractor
  import sbie_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sbie_in_if.sink    in_i,
  sbie_out_if.source out_o
);

  typedef enum logic [1:0] {
    PhSearch  = 2'd0,
    PhHeader  = 2'd1,
    PhPayload = 2'd2,
    PhDone    = 2'd3
  } phase_e;

  byte_t   win_q [WinLen];
  logic [4:0] fill_q, fill_d;
  logic [3:0] skip_q, skip_d;
  phase_e  phase_q, phase_d;
  logic [2:0] hidx_q, hidx_d;
  logic    final_q, final_d;
  byte_t   len_low_q, len_low_d;
  logic [15:0] left_q, left_d;

  logic    out_valid_q;
  byte_t   out_byte_q;
  logic    pay_q, done_q;
  status_e status_q;

  logic    accept;
  logic    emit;
  status_e status_d;
  match_t  match;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  sbie_match u_match (
    .win_i   (win_q),
    .byte_i  (in_i.data_byte),
    .match_o (match)
  );

  always_comb begin
    fill_d    = fill_q;
    skip_d    = skip_q;
    phase_d   = phase_q;
    hidx_d    = hidx_q;
    final_d   = final_q;
    len_low_d = len_low_q;
    left_d    = left_q;
    emit      = 1'b0;
    status_d  = StOk;
    unique case (phase_q)
      PhSearch: begin
        if (fill_q < WinFull) begin
          fill_d = fill_q + 5'd1;
        end
        if (fill_d == WinFull) begin
          if (skip_q != 4'd0) begin
            skip_d = skip_q - 4'd1;
          end else if (match.magic) begin
            if (match.tail) begin
              phase_d = PhPayload;
              left_d  = FirstBlockLen;
              final_d = 1'b0;
            end else begin
              skip_d = SkipAfterMiss;
            end
          end
        end
      end
      PhHeader: begin
        unique case (hidx_q)
          3'd0: final_d = (in_i.data_byte == 8'd1);
          3'd1: len_low_d = in_i.data_byte;
          3'd2: left_d = {in_i.data_byte, len_low_q};
          default: ;
        endcase
        if (hidx_q >= HdrLast) begin
          hidx_d = 3'd0;
          if (left_d == 16'd0) begin
            phase_d = final_d ? PhDone : PhHeader;
          end else begin
            phase_d = PhPayload;
          end
        end else begin
          hidx_d = hidx_q + 3'd1;
        end
      end
      PhPayload: begin
        emit   = 1'b1;
        left_d = left_q - 16'd1;
        if (left_d == 16'd0) begin
          phase_d = final_q ? PhDone : PhHeader;
          hidx_d  = 3'd0;
        end
      end
      PhDone: ;
      default: ;
    endcase
    if (in_i.end_of_file) begin
      priority if (phase_d == PhSearch) begin
        status_d = StNotFound;
      end else if (phase_d == PhPayload) begin
        status_d = StTrunc;
      end else begin
        status_d = StOk;
      end
      fill_d  = 5'd0;
      skip_d  = 4'd0;
      phase_d = PhSearch;
      hidx_d  = 3'd0;
      final_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= 5'd0;
      skip_q      <= 4'd0;
      phase_q     <= PhSearch;
      hidx_q      <= 3'd0;
      final_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        fill_q  <= fill_d;
        skip_q  <= skip_d;
        phase_q <= phase_d;
        hidx_q  <= hidx_d;
        final_q <= final_d;
      end
      if (accept) begin
        out_valid_q <= emit || in_i.end_of_file;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_low_q  <= len_low_d;
      left_q     <= left_d;
      out_byte_q <= emit ? in_i.data_byte : 8'd0;
      pay_q      <= emit;
      done_q     <= in_i.end_of_file;
      status_q   <= status_d;
      if (phase_q == PhSearch) begin
        for (int i = 0; i < WinLen - 1; i++) begin
          win_q[i] <= win_q[i+1];
        end
        win_q[WinLen-1] <= in_i.data_byte;
      end
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_byte      = out_byte_q;
  assign out_o.payload_valid = pay_q;
  assign out_o.file_done     = done_q;
  assign out_o.status        = status_q;

  a_status_only_at_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !done_q |-> status_q == StOk)
    else $error("status set on a result that is not the end of the file");

  a_skip_only_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q != 4'd0 |-> phase_q == PhSearch)
    else $error("skip count left over outside the search");

  a_hidx_only_in_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hidx_q != 3'd0 |-> phase_q == PhHeader)
    else $error("header index left over outside header parsing");

  a_payload_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhPayload |-> left_q != 16'd0)
    else $error("payload phase with no bytes left");

  a_emit_from_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && phase_q != PhPayload |=> !(out_valid_q && pay_q))
    else $error("payload byte sent outside the payload phase");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for stored_block_image_extractor: random and directed container files.
// A scoreboard class predicts payload bytes and end-of-file status from every accepted byte.
// Depends on sbie_pkg, sbie_in_if, sbie_out_if and the extractor RTL.
module tb_top;
  import sbie_pkg::*;

  localparam int StallLimit = 2000;

  typedef enum logic [1:0] {
    PhSearch,
    PhHeader,
    PhPayload,
    PhDone
  } parse_phase_e;

  typedef struct packed {
    byte_t   data;
    logic    payload;
    logic    done;
    status_e status;
  } extract_result_t;

  typedef byte_t byte_q_t[$];

  class extract_scoreboard;
    byte_t           window [WinLen];
    logic [4:0]      fill;
    logic [3:0]      skip;
    parse_phase_e    phase;
    logic [2:0]      hdr_idx;
    logic            last_block;
    byte_t           len_low;
    logic [15:0]     remaining;
    extract_result_t expected_q[$];
    int              errors;
    int              files;
    int              bytes_in;
    int              payload_out;
    int              status_seen [3];

    function new();
      errors = 0;
      files = 0;
      bytes_in = 0;
      payload_out = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      foreach (window[i]) window[i] = '0;
      fill = '0;
      skip = '0;
      phase = PhSearch;
      hdr_idx = '0;
      last_block = 1'b0;
      len_low = '0;
      remaining = '0;
    endfunction

    function void close_block();
      if (last_block) begin
        phase = PhDone;
      end else begin
        phase = PhHeader;
        hdr_idx = '0;
      end
    endfunction

    function void note_byte(byte_t b, logic eof);
      extract_result_t res;
      logic emitted;
      logic magic_hit;
      logic tail_hit;
      emitted = 1'b0;
      bytes_in++;
      case (phase)
        PhSearch: begin
          for (int i = 0; i < WinLen - 1; i++) window[i] = window[i + 1];
          window[WinLen - 1] = b;
          if (fill < WinFull) fill++;
          if (fill == WinFull) begin
            if (skip != 0) begin
              skip--;
            end else begin
              magic_hit = 1'b1;
              tail_hit = 1'b1;
              for (int i = 0; i < SigLen; i++) begin
                if (window[i] != SigMagic[i]) magic_hit = 1'b0;
                if (window[TailOfs + i] != SigTail[i]) tail_hit = 1'b0;
              end
              if (magic_hit && tail_hit) begin
                phase = PhPayload;
                remaining = FirstBlockLen;
                last_block = 1'b0;
              end else if (magic_hit) begin
                skip = SkipAfterMiss;
              end
            end
          end
        end
        PhHeader: begin
          case (hdr_idx)
            3'd0: last_block = (b == 8'h01);
            3'd1: len_low = b;
            3'd2: remaining = {b, len_low};
            default: ;
          endcase
          if (hdr_idx >= HdrLast) begin
            hdr_idx = '0;
            if (remaining == 0) close_block();
            else phase = PhPayload;
          end else begin
            hdr_idx++;
          end
        end
        PhPayload: begin
          emitted = 1'b1;
          payload_out++;
          remaining--;
          if (remaining == 0) close_block();
        end
        default: ;
      endcase
      if (!emitted && !eof) return;
      res.data = emitted ? b : '0;
      res.payload = emitted;
      res.done = eof;
      res.status = StOk;
      if (eof) begin
        if (phase == PhSearch) res.status = StNotFound;
        else if (phase == PhPayload) res.status = StTrunc;
        files++;
        status_seen[int'(res.status)]++;
        clear_parser();
      end
      expected_q.push_back(res);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task check_result(byte_t data, logic pv, logic done, logic [1:0] st);
      extract_result_t exp_res;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected transaction, byte %02h done %b", data, done));
        return;
      end
      exp_res = expected_q.pop_front();
      if (pv !== exp_res.payload)
        report($sformatf("payload_valid %b, predicted %b", pv, exp_res.payload));
      if (data !== exp_res.data)
        report($sformatf("out_byte %02h, predicted %02h", data, exp_res.data));
      if (done !== exp_res.done)
        report($sformatf("file_done %b, predicted %b", done, exp_res.done));
      if (st !== exp_res.status)
        report($sformatf("status %0d, predicted %0d", st, exp_res.status));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  sbie_in_if  in_if ();
  sbie_out_if out_if ();

  stored_block_image_extractor DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  extract_scoreboard sb = new();
  byte_q_t file_q;
  logic calm;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 0;
    if (r < 9) return $urandom_range(1, 40);
    return $urandom_range(256, 600);
  endfunction

  function automatic void add_noise(int n);
    repeat (n) file_q.push_back(byte_t'($urandom_range(0, 255)));
  endfunction

  function automatic void add_payload(int n);
    add_noise(n);
  endfunction

  function automatic void add_magic();
    for (int i = 0; i < SigLen; i++) file_q.push_back(SigMagic[i]);
  endfunction

  function automatic void add_start(logic spoil);
    byte_t b;
    int pos;
    pos = $urandom_range(0, SigLen - 1);
    add_magic();
    add_noise(4);
    for (int i = 0; i < SigLen; i++) begin
      b = SigTail[i];
      if (spoil && i == pos) b ^= byte_t'($urandom_range(1, 255));
      file_q.push_back(b);
    end
  endfunction

  function automatic void add_header(logic last, logic [15:0] len);
    byte_t flag;
    flag = byte_t'($urandom_range(0, 255));
    if (flag == 8'h01) flag = 8'h00;
    file_q.push_back(last ? 8'h01 : flag);
    file_q.push_back(len[7:0]);
    file_q.push_back(len[15:8]);
    add_noise(2);
  endfunction

  task automatic send_byte(byte_t b, logic eof);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data_byte = b;
    in_if.end_of_file = eof;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && in_if.valid === 1'b1 && in_if.ready === 1'b1)
      sb.note_byte(in_if.data_byte, in_if.end_of_file);
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(out_if.out_byte, out_if.payload_valid, out_if.file_done, out_if.status);
  end

  initial begin
    int burst;
    int stall;
    out_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 30);
      out_if.ready = 1'b1;
      repeat (burst) @(negedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    @(posedge rst_ni);
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) idle = 0;
      else idle++;
    end
    $display("Timeout with %0d results outstanding", sb.expected_q.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int counted;
    int file_no;
    int longs;
    int kind;
    int len;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.end_of_file = 1'b0;
    calm = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    file_q.push_back(8'hFF);
    send_file();
    add_start(1'b0);
    void'(file_q.pop_back());
    send_file();
    repeat (20) file_q.push_back(8'h00);
    send_file();
    add_start(1'b0);
    send_file();
    add_magic();
    add_noise(4);
    add_start(1'b0);
    add_noise(3);
    send_file();
    add_magic();
    add_noise(5);
    add_start(1'b0);
    add_payload(3);
    send_file();
    add_noise(30);
    add_start(1'b0);
    add_payload(10);
    send_file();
    add_start(1'b1);
    add_noise(40);
    send_file();
    drain();

    calm = 1'b1;
    add_start(1'b0);
    add_payload(int'(FirstBlockLen));
    add_header(1'b0, 16'd0);
    add_header(1'b0, 16'd3);
    add_payload(3);
    add_header(1'b1, 16'd4);
    file_q.push_back(8'h00);
    file_q.push_back(8'hFF);
    add_payload(2);
    file_q.push_back(8'hFF);
    file_q.push_back(8'h00);
    add_start(1'b0);
    send_file();
    calm = 1'b0;
    add_start(1'b0);
    add_payload(int'(FirstBlockLen));
    add_header(1'b1, 16'd0);
    add_noise(6);
    send_file();
    add_start(1'b0);
    add_payload(int'(FirstBlockLen));
    add_header(1'b0, 16'd2);
    add_payload(2);
    file_q.push_back(8'h01);
    file_q.push_back(8'h05);
    send_file();

    counted = 0;
    file_no = 0;
    longs = 0;
    while (counted < 1500) begin
      calm = ($urandom_range(0, 3) == 0);
      if (file_no % 15 == 7 && longs < 1) begin
        longs++;
        add_start(1'b0);
        add_payload(int'(FirstBlockLen));
        kind = $urandom_range(0, 3);
        if (kind != 0) begin
          repeat ($urandom_range(0, 5)) begin
            len = pick_len();
            add_header(1'b0, 16'(len));
            add_payload(len);
          end
          case (kind)
            1: begin
              len = pick_len();
              add_header(1'b1, 16'(len));
              add_payload(len);
              add_noise($urandom_range(0, 10));
            end
            2: begin
              len = pick_len() + 1;
              add_header(1'b0, 16'(len));
              add_payload($urandom_range(1, len));
            end
            default: add_noise($urandom_range(1, 4));
          endcase
        end
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
          add_noise($urandom_range(0, 30));
          add_start(1'b0);
          add_payload($urandom_range(0, 40));
        end else if (kind < 7) begin
          add_noise($urandom_range(1, 60));
        end else if (kind < 9) begin
          add_noise($urandom_range(0, 10));
          add_start(1'b1);
          add_noise($urandom_range(0, 20));
        end else begin
          add_noise($urandom_range(0, 5));
          add_magic();
          add_noise($urandom_range(0, 12));
          add_start(1'b0);
          add_payload($urandom_range(0, 10));
        end
        counted += file_q.size();
      end
      send_file();
      file_no++;
      if (file_no % 10 == 0) drain();
    end

    drain();
    repeat (10) @(negedge clk_i);
    $display("Covered %0d files: %0d ok, %0d start not found, %0d truncated",
             sb.files, sb.status_seen[int'(StOk)], sb.status_seen[int'(StNotFound)],
             sb.status_seen[int'(StTrunc)]);
    $display("%0d file bytes in, %0d payload bytes out, %0d mismatches",
             sb.bytes_in, sb.payload_out, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/sbie_pkg.sv
rtl/sbie_in_if.sv
rtl/sbie_out_if.sv
rtl/sbie_match.sv
rtl/stored_block_image_extractor.sv
test/tb_top.sv
